[rtl/core/dns_answer_record_parser_defines.svh]
// ----------------------------------------------------------------------------
// DNS answer record parser assertion macros
// Shared assertion macros for the parser front end, queue and output stage.
// ----------------------------------------------------------------------------
`ifndef DNS_ANSWER_RECORD_PARSER_DEFINES_SVH
`define DNS_ANSWER_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DARP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("darp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DARP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("darp assertion failed");

`endif

[rtl/core/darp_pkg.sv]
// ----------------------------------------------------------------------------
// DNS answer record parser package
// Phase codes, record type codes, queue sizing and the result record type.
// ----------------------------------------------------------------------------
package darp_pkg;

  typedef enum logic [2:0] {
    PH_DONE  = 3'd0,
    PH_NAME  = 3'd1,
    PH_PTR2  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_CLASS = 3'd4,
    PH_TTL   = 3'd5,
    PH_LEN   = 3'd6,
    PH_RDATA = 3'd7
  } phase_t;

  localparam logic [15:0] TypeA    = 16'd1;
  localparam logic [15:0] TypePtr  = 16'd12;
  localparam logic [15:0] TypeAaaa = 16'd28;
  localparam logic [15:0] LenA     = 16'd4;
  localparam logic [15:0] LenAaaa  = 16'd16;
  localparam logic [7:0]  PtrMark  = 8'hC0;
  localparam logic [15:0] PtrMaxReset = 16'd255;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic        is_header;
    logic [15:0] rec_type;
    logic [31:0] time_to_live;
    logic [15:0] rd_length;
    logic [7:0]  out_byte;
    logic        last_of_record;
  } result_t;

  // Status of the queue as seen by the output stage.
  typedef struct packed {
    logic    valid;
    result_t data;
  } queue_head_t;

endpackage

[rtl/core/darp_ifs.sv]
// ----------------------------------------------------------------------------
// DNS answer record parser channels
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface darp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        section_start;
  logic [15:0] answer_count;
  modport source(output valid, data_byte, section_start, answer_count, input ready);
  modport sink(input valid, data_byte, section_start, answer_count, output ready);
endinterface

interface darp_out_if;
  logic        valid;
  logic        ready;
  logic        is_header;
  logic [15:0] rec_type;
  logic [31:0] time_to_live;
  logic [15:0] rd_length;
  logic [7:0]  out_byte;
  logic        last_of_record;
  modport source(output valid, is_header, rec_type, time_to_live, rd_length, out_byte,
                 last_of_record, input ready);
  modport sink(input valid, is_header, rec_type, time_to_live, rd_length, out_byte,
               last_of_record, output ready);
endinterface

interface darp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] pointer_name_max;
  modport source(output valid, pointer_name_max, input ready);
  modport sink(input valid, pointer_name_max, output ready);
endinterface

[rtl/core/darp_front.sv]
// ----------------------------------------------------------------------------
// DNS answer record parser front end
// Walks the record fields byte by byte and pushes header and rdata results.
// ----------------------------------------------------------------------------
`include "dns_answer_record_parser_defines.svh"

module darp_front (
  input  logic                clk,
  input  logic                rst,
  darp_in_if.sink             rx,
  darp_cfg_if.sink            cfg,
  input  logic                q_full,
  output logic                push,
  output darp_pkg::result_t   push_data
);

  darp_pkg::phase_t phase, phase_next, ph_eff;
  logic [1:0]  field_byte_index, field_byte_index_next;
  logic [15:0] records_left, records_left_next;
  logic [15:0] cur_type, cur_type_next;
  logic [31:0] cur_ttl, cur_ttl_next;
  logic [15:0] cur_length, cur_length_next;
  logic [15:0] rdata_left, rdata_left_next;
  logic        record_accepted, record_accepted_next;
  logic [15:0] pointer_name_max;
  logic        beat;
  logic        emit;
  logic        end_rec;
  logic [7:0]  b;

  assign rx.ready  = !q_full;
  assign cfg.ready = 1'b1;
  assign beat      = rx.valid && rx.ready;
  assign b         = rx.data_byte;
  assign push      = beat && emit;

  always_comb begin
    records_left_next     = records_left;
    field_byte_index_next = field_byte_index;
    record_accepted_next  = record_accepted;
    cur_type_next         = cur_type;
    cur_ttl_next          = cur_ttl;
    cur_length_next       = cur_length;
    rdata_left_next       = rdata_left;
    ph_eff                = phase;
    emit                  = 1'b0;
    end_rec               = 1'b0;
    push_data             = '0;

    // A section start abandons any record in progress.
    if (rx.section_start) begin
      records_left_next     = rx.answer_count;
      field_byte_index_next = 2'd0;
      record_accepted_next  = 1'b0;
      ph_eff = (rx.answer_count == 16'd0) ? darp_pkg::PH_DONE : darp_pkg::PH_NAME;
    end
    phase_next = ph_eff;

    unique case (ph_eff)
      darp_pkg::PH_NAME: begin
        if (field_byte_index_next == 2'd0 && (b & darp_pkg::PtrMark) == darp_pkg::PtrMark) begin
          phase_next = darp_pkg::PH_PTR2;
        end else if (b == 8'd0) begin
          phase_next            = darp_pkg::PH_TYPE;
          field_byte_index_next = 2'd0;
          cur_type_next         = 16'd0;
        end else begin
          field_byte_index_next = 2'd1;
        end
      end
      darp_pkg::PH_PTR2: begin
        phase_next            = darp_pkg::PH_TYPE;
        field_byte_index_next = 2'd0;
        cur_type_next         = 16'd0;
      end
      darp_pkg::PH_TYPE: begin
        cur_type_next = {cur_type[7:0], b};
        if (field_byte_index_next == 2'd1) begin
          phase_next            = darp_pkg::PH_CLASS;
          field_byte_index_next = 2'd0;
        end else begin
          field_byte_index_next = 2'd1;
        end
      end
      darp_pkg::PH_CLASS: begin
        if (field_byte_index_next == 2'd1) begin
          phase_next            = darp_pkg::PH_TTL;
          field_byte_index_next = 2'd0;
          cur_ttl_next          = 32'd0;
        end else begin
          field_byte_index_next = 2'd1;
        end
      end
      darp_pkg::PH_TTL: begin
        cur_ttl_next = {cur_ttl[23:0], b};
        if (field_byte_index_next == 2'd3) begin
          phase_next            = darp_pkg::PH_LEN;
          field_byte_index_next = 2'd0;
          cur_length_next       = 16'd0;
        end else begin
          field_byte_index_next = field_byte_index_next + 2'd1;
        end
      end
      darp_pkg::PH_LEN: begin
        cur_length_next = {cur_length[7:0], b};
        if (field_byte_index_next == 2'd0) begin
          field_byte_index_next = 2'd1;
        end else begin
          field_byte_index_next = 2'd0;
          rdata_left_next       = cur_length_next;
          if (cur_type == darp_pkg::TypeA) begin
            record_accepted_next = (cur_length_next == darp_pkg::LenA);
          end else if (cur_type == darp_pkg::TypeAaaa) begin
            record_accepted_next = (cur_length_next == darp_pkg::LenAaaa);
          end else if (cur_type == darp_pkg::TypePtr) begin
            record_accepted_next = (cur_length_next <= pointer_name_max);
          end else begin
            record_accepted_next = 1'b1;
          end
          emit                     = record_accepted_next;
          push_data.is_header      = 1'b1;
          push_data.rec_type       = cur_type;
          push_data.time_to_live   = cur_ttl;
          push_data.rd_length      = cur_length_next;
          push_data.last_of_record = (cur_length_next == 16'd0);
          if (cur_length_next == 16'd0) begin
            end_rec = 1'b1;
          end else begin
            phase_next = darp_pkg::PH_RDATA;
          end
        end
      end
      darp_pkg::PH_RDATA: begin
        emit                     = record_accepted_next;
        push_data.rec_type       = cur_type;
        push_data.time_to_live   = cur_ttl;
        push_data.rd_length      = cur_length;
        push_data.out_byte       = b;
        push_data.last_of_record = (rdata_left == 16'd1);
        rdata_left_next          = rdata_left - 16'd1;
        if (rdata_left_next == 16'd0) begin
          end_rec = 1'b1;
        end
      end
      darp_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (end_rec) begin
      records_left_next     = records_left_next - 16'd1;
      field_byte_index_next = 2'd0;
      phase_next = (records_left_next == 16'd0) ? darp_pkg::PH_DONE : darp_pkg::PH_NAME;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= darp_pkg::PH_DONE;
      field_byte_index <= 2'd0;
      records_left     <= 16'd0;
      cur_type         <= 16'd0;
      cur_ttl          <= 32'd0;
      cur_length       <= 16'd0;
      rdata_left       <= 16'd0;
      record_accepted  <= 1'b0;
    end else if (beat) begin
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      records_left     <= records_left_next;
      cur_type         <= cur_type_next;
      cur_ttl          <= cur_ttl_next;
      cur_length       <= cur_length_next;
      rdata_left       <= rdata_left_next;
      record_accepted  <= record_accepted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_name_max <= darp_pkg::PtrMaxReset;
    end else if (cfg.valid && cfg.ready) begin
      pointer_name_max <= cfg.pointer_name_max;
    end
  end

  `DARP_ASSERT_NOW(a_done_no_records, clk, rst, phase == darp_pkg::PH_DONE, records_left == 16'd0)
  `DARP_ASSERT_NOW(a_rdata_nonzero, clk, rst, phase == darp_pkg::PH_RDATA, rdata_left != 16'd0)

endmodule

[rtl/core/darp_queue.sv]
// ----------------------------------------------------------------------------
// DNS answer record parser result queue
// Short FIFO that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`include "dns_answer_record_parser_defines.svh"

module darp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  darp_pkg::result_t     push_data,
  output logic                  full,
  input  logic                  pop,
  output darp_pkg::queue_head_t head
);

  darp_pkg::result_t                 slots [darp_pkg::QueueDepth];
  logic [darp_pkg::QueuePtrW-1:0]    wr_ptr;
  logic [darp_pkg::QueuePtrW-1:0]    rd_ptr;
  logic [darp_pkg::QueueCntW-1:0]    count;

  assign full       = (count == darp_pkg::QueueCntW'(darp_pkg::QueueDepth));
  assign head.valid = (count != '0);
  assign head.data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DARP_ASSERT_NOW(a_no_push_full, clk, rst, push, !full)
  `DARP_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, head.valid)

endmodule

[rtl/core/darp_back.sv]
// ----------------------------------------------------------------------------
// DNS answer record parser output stage
// Output register that drains the queue onto the result channel.
// ----------------------------------------------------------------------------
`include "dns_answer_record_parser_defines.svh"

module darp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  darp_pkg::queue_head_t head,
  output logic                  pop,
  darp_out_if.source            tx
);

  logic              out_valid;
  darp_pkg::result_t out_data;
  logic              slot_free;

  assign slot_free = !out_valid || tx.ready;
  assign pop       = head.valid && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head.data;
    end
  end

  assign tx.valid          = out_valid;
  assign tx.is_header      = out_data.is_header;
  assign tx.rec_type       = out_data.rec_type;
  assign tx.time_to_live   = out_data.time_to_live;
  assign tx.rd_length      = out_data.rd_length;
  assign tx.out_byte       = out_data.out_byte;
  assign tx.last_of_record = out_data.last_of_record;

  `DARP_ASSERT_NEXT(a_pop_loads, clk, rst, pop, out_valid)

endmodule

[rtl/core/dns_answer_record_parser.sv]
// ----------------------------------------------------------------------------
// DNS answer record parser
// Parses the answer section of a DNS response and emits record results.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one answer-section byte per beat. The beat with section_start
//   high is the first byte of the first record and samples answer_count.
//   tx carries one result per beat: a header beat (is_header high) for each
//   accepted record, then one beat per rdata byte; last_of_record marks the
//   final beat of a record. Rejected records and trailing bytes give nothing.
//   cfg writes pointer_name_max, the largest rdata length allowed for a PTR
//   record; it is always ready and should only be written while idle.
// Timing:
//   One byte is taken per cycle while the queue is not full. Each result is
//   written into the four-entry queue on its byte's beat, and the output
//   register loads it from the queue head once that register is free.
//   rx.ready drops only while the four-entry queue is full, so a stalled tx
//   holds its beat and the parser keeps going until the queue fills.
// Reset:
//   rst is synchronous. It empties the queue and output register, returns the
//   parser to the idle section state and sets pointer_name_max to 255.
// ----------------------------------------------------------------------------
module dns_answer_record_parser (
  input  logic        clk,
  input  logic        rst,
  darp_in_if.sink     rx,
  darp_cfg_if.sink    cfg,
  darp_out_if.source  tx
);

  logic                  q_full;
  logic                  push;
  darp_pkg::result_t     push_data;
  logic                  pop;
  darp_pkg::queue_head_t head;

  darp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  darp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  darp_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .tx   (tx)
  );

endmodule

[tb/dns_answer_record_parser_test.sv]
// ----------------------------------------------------------------------------
// DNS answer record parser testbench
// Streams answer sections into the parser byte by byte and tracks every rx
// beat with a behavioral parser of its own. Each tx beat is checked field by
// field against the oldest predicted result. The run steps through several
// PTR length limits and through phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module dns_answer_record_parser_test;
  import darp_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int ItemsPerPhase = 275;
  localparam int SettleCycles  = 8;

  typedef struct {
    logic [7:0]  data_byte;
    logic        section_start;
    logic [15:0] answer_count;
    bit          hold;
  } rx_beat_t;

  logic clk = 1'b0;
  logic rst;

  darp_in_if  rx_ch ();
  darp_out_if tx_ch ();
  darp_cfg_if cfg_ch ();

  dns_answer_record_parser dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cfg (cfg_ch),
    .tx  (tx_ch)
  );

  always #6 clk = ~clk;

  rx_beat_t    pending_beats[$];
  rx_beat_t    section_bytes[$];
  result_t     results_due[$];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned items_made;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          rx_beat_taken;

  // Parser state as the block should hold it.
  logic [15:0] ptr_name_limit = PtrMaxReset;
  phase_t      parse_phase    = PH_DONE;
  logic [1:0]  field_idx      = 2'd0;
  logic [15:0] records_left   = 16'd0;
  logic [15:0] rec_type_q     = 16'd0;
  logic [31:0] ttl_q          = 32'd0;
  logic [15:0] rec_len_q      = 16'd0;
  logic [15:0] rdata_left     = 16'd0;
  logic        rec_kept       = 1'b0;

  task automatic queue_result(input logic hdr, input logic [7:0] b, input logic last);
    result_t r;
    r.is_header      = hdr;
    r.rec_type       = rec_type_q;
    r.time_to_live   = ttl_q;
    r.rd_length      = rec_len_q;
    r.out_byte       = b;
    r.last_of_record = last;
    results_due.push_back(r);
  endtask

  task automatic finish_record();
    records_left = records_left - 16'd1;
    field_idx    = 2'd0;
    parse_phase  = (records_left == 16'd0) ? PH_DONE : PH_NAME;
  endtask

  task automatic parse_answer_byte(input logic [7:0] b, input logic start,
                                   input logic [15:0] count);
    if (start) begin
      records_left = count;
      field_idx    = 2'd0;
      rec_kept     = 1'b0;
      parse_phase  = (count == 16'd0) ? PH_DONE : PH_NAME;
    end
    case (parse_phase)
      PH_NAME: begin
        // Only the first byte of an owner name can be a compression pointer.
        if (field_idx == 2'd0 && (b & PtrMark) == PtrMark) begin
          parse_phase = PH_PTR2;
        end else if (b == 8'd0) begin
          parse_phase = PH_TYPE;
          field_idx   = 2'd0;
          rec_type_q  = 16'd0;
        end else begin
          field_idx = 2'd1;
        end
      end
      PH_PTR2: begin
        parse_phase = PH_TYPE;
        field_idx   = 2'd0;
        rec_type_q  = 16'd0;
      end
      PH_TYPE: begin
        rec_type_q = {rec_type_q[7:0], b};
        if (field_idx == 2'd1) begin
          parse_phase = PH_CLASS;
          field_idx   = 2'd0;
        end else begin
          field_idx = 2'd1;
        end
      end
      PH_CLASS: begin
        if (field_idx == 2'd1) begin
          parse_phase = PH_TTL;
          field_idx   = 2'd0;
          ttl_q       = 32'd0;
        end else begin
          field_idx = 2'd1;
        end
      end
      PH_TTL: begin
        ttl_q = {ttl_q[23:0], b};
        if (field_idx == 2'd3) begin
          parse_phase = PH_LEN;
          field_idx   = 2'd0;
          rec_len_q   = 16'd0;
        end else begin
          field_idx = field_idx + 2'd1;
        end
      end
      PH_LEN: begin
        rec_len_q = {rec_len_q[7:0], b};
        if (field_idx == 2'd0) begin
          field_idx = 2'd1;
        end else begin
          field_idx  = 2'd0;
          rdata_left = rec_len_q;
          if (rec_type_q == TypeA) rec_kept = (rec_len_q == LenA);
          else if (rec_type_q == TypeAaaa) rec_kept = (rec_len_q == LenAaaa);
          else if (rec_type_q == TypePtr) rec_kept = (rec_len_q <= ptr_name_limit);
          else rec_kept = 1'b1;
          if (rec_kept) queue_result(1'b1, 8'd0, rec_len_q == 16'd0);
          if (rec_len_q == 16'd0) finish_record();
          else parse_phase = PH_RDATA;
        end
      end
      PH_RDATA: begin
        if (rec_kept) queue_result(1'b0, b, rdata_left == 16'd1);
        rdata_left = rdata_left - 16'd1;
        if (rdata_left == 16'd0) finish_record();
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_beat(input logic [7:0] b);
    rx_beat_t beat;
    beat.data_byte     = b;
    beat.section_start = 1'b0;
    beat.answer_count  = 16'($urandom);
    beat.hold          = 1'b0;
    section_bytes.push_back(beat);
  endtask

  // One answer section of well-formed records with random content. Some
  // sections lie about their count or get cut off so the next section start
  // lands in the middle of a record.
  task automatic build_section(input logic [15:0] ptr_lim);
    int unsigned n, style, cut;
    logic [15:0] count, rtype, len;
    logic [31:0] ttl;
    section_bytes.delete();
    n = $urandom_range(1, 5);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: begin
          add_beat(8'($urandom_range(8'hC0, 8'hFF)));
          add_beat(8'($urandom));
        end
        1: add_beat(8'd0);
        default: begin
          add_beat(8'($urandom_range(1, 8'hBF)));
          repeat ($urandom_range(0, 8)) add_beat(8'($urandom_range(1, 255)));
          add_beat(8'd0);
        end
      endcase
      case ($urandom_range(0, 3))
        0: begin
          rtype = TypeA;
          len   = ($urandom_range(0, 9) != 0) ? LenA : 16'($urandom_range(0, 20));
        end
        1: begin
          rtype = TypeAaaa;
          len   = ($urandom_range(0, 6) != 0) ? LenAaaa : 16'($urandom_range(0, 20));
        end
        2: begin
          rtype = TypePtr;
          if (ptr_lim <= 16'd40 && $urandom_range(0, 1) == 1)
            len = ptr_lim + 16'($urandom_range(0, 1));
          else if ($urandom_range(0, 29) == 0) len = 16'($urandom_range(250, 300));
          else len = 16'($urandom_range(0, 24));
        end
        default: begin
          rtype = 16'($urandom);
          len   = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
        end
      endcase
      case ($urandom_range(0, 7))
        0: ttl = 32'd0;
        1: ttl = 32'hFFFF_FFFF;
        default: ttl = $urandom;
      endcase
      add_beat(rtype[15:8]);
      add_beat(rtype[7:0]);
      add_beat(8'($urandom));
      add_beat(8'($urandom));
      add_beat(ttl[31:24]);
      add_beat(ttl[23:16]);
      add_beat(ttl[15:8]);
      add_beat(ttl[7:0]);
      add_beat(len[15:8]);
      add_beat(len[7:0]);
      repeat (len) add_beat(8'($urandom));
    end
    count = 16'(n);
    style = $urandom_range(0, 11);
    case (style)
      0: count = 16'd0;
      1: count = 16'(n + $urandom_range(1, 2));
      2: begin
        cut = $urandom_range(1, section_bytes.size() - 1);
        section_bytes = section_bytes[0:cut-1];
      end
      3: count = 16'($urandom_range(n + 1, 16'hFFFF));
      default: ;
    endcase
    section_bytes[0].section_start = 1'b1;
    section_bytes[0].answer_count  = count;
    if ($urandom_range(0, 7) == 0)
      section_bytes[$urandom_range(0, section_bytes.size() - 1)].hold = 1'b1;
    if (count != 16'd0) items_made += section_bytes.size();
    // Trailing bytes after a complete section are ignored by the parser.
    repeat ($urandom_range(0, 3)) add_beat(8'($urandom));
    pending_beats = {pending_beats, section_bytes};
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || rx_ch.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(negedge clk) begin : byte_driver
    rx_beat_t nxt;
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_beat_taken) begin
      // A held beat waits until every predicted result has come out.
      if (pending_beats.size() != 0 && !(pending_beats[0].hold && results_due.size() != 0)
          && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_beats.pop_front();
        rx_ch.valid         <= 1'b1;
        rx_ch.data_byte     <= nxt.data_byte;
        rx_ch.section_start <= nxt.section_start;
        rx_ch.answer_count  <= nxt.answer_count;
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) tx_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin : beat_monitor
    result_t want;
    if (rst) begin
      rx_beat_taken = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) ptr_name_limit = cfg_ch.pointer_name_max;
      rx_beat_taken = rx_ch.valid && rx_ch.ready;
      if (rx_beat_taken)
        parse_answer_byte(rx_ch.data_byte, rx_ch.section_start, rx_ch.answer_count);
      if (tx_ch.valid === 1'b1 && tx_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %0b/0x%0h/0x%0h",
                   $time, tx_ch.is_header, tx_ch.rec_type, tx_ch.out_byte);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("is_header", 32'(want.is_header), 32'(tx_ch.is_header));
          check_field("rec_type", 32'(want.rec_type), 32'(tx_ch.rec_type));
          check_field("time_to_live", want.time_to_live, tx_ch.time_to_live);
          check_field("rd_length", 32'(want.rd_length), 32'(tx_ch.rd_length));
          check_field("out_byte", 32'(want.out_byte), 32'(tx_ch.out_byte));
          check_field("last_of_record", 32'(want.last_of_record),
                      32'(tx_ch.last_of_record));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("** dns_answer_record_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [15:0] limits [4];
    int unsigned idle_pcts [4];
    int unsigned stall_pcts [4];
    logic [7:0] opening [20];
    rst                     = 1'b1;
    rx_ch.valid             = 1'b0;
    rx_ch.data_byte         = 8'd0;
    rx_ch.section_start     = 1'b0;
    rx_ch.answer_count      = 16'd0;
    tx_ch.ready             = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.pointer_name_max = 16'd0;
    limits     = '{PtrMaxReset, 16'd0, 16'hFFFF, 16'($urandom_range(1, 40))};
    idle_pcts  = '{0, 70, 0, 19};
    stall_pcts = '{0, 0, 70, 19};
    send_idle_pct = idle_pcts[0];
    stall_pct     = stall_pcts[0];
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // A stray byte while idle, an empty section, then an A record with a
    // pointer name and extreme TTL bytes in a section of 65535 records, cut
    // off by a restart after a plain label byte.
    opening = '{8'hFF, 8'h00, 8'hC0, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                8'h80, 8'h01, 8'h00, 8'h04, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h80, 8'h00};
    section_bytes.delete();
    foreach (opening[i]) add_beat(opening[i]);
    section_bytes[1].section_start  = 1'b1;
    section_bytes[1].answer_count   = 16'd0;
    section_bytes[2].section_start  = 1'b1;
    section_bytes[2].answer_count   = 16'hFFFF;
    section_bytes[19].section_start = 1'b1;
    section_bytes[19].answer_count  = 16'd1;
    pending_beats = {pending_beats, section_bytes};

    for (int p = 0; p < 4; p++) begin
      if (p != 0) begin
        wait_idle();
        @(negedge clk);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.pointer_name_max <= limits[p];
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk) cfg_ch.valid <= 1'b0;
      end
      send_idle_pct = idle_pcts[p];
      stall_pct     = stall_pcts[p];
      while (items_made < (p + 1) * ItemsPerPhase) build_section(limits[p]);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("** dns_answer_record_parser: PASSED **");
    end else begin
      $display("** dns_answer_record_parser: FAILED **");
    end
    $finish;
  end

endmodule
